// ===== rtl/spq_pkg.sv =====
// shared constants and types for the sorted priority queue
package spq_pkg;

   localparam int unsigned DEFAULT_CAPACITY      = 16;
   localparam int unsigned DEFAULT_VALUE_BITS    = 32;
   localparam int unsigned DEFAULT_PRIORITY_BITS = 16;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef enum logic [2:0] {
      RA_IDX_M1,
      RA_IDX_M2,
      RA_ZERO,
      RA_ONE,
      RA_IDX_P1
   } rd_addr_sel_type;

   typedef enum logic {
      WA_IDX,
      WA_IDX_M1
   } wr_addr_sel_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_DEC,
      IDX_INC,
      IDX_ONE
   } idx_op_type;

   typedef struct packed {
      logic            capture;
      logic            rd_en;
      rd_addr_sel_type rd_sel;
      logic            wr_en;
      wr_addr_sel_type wa_sel;
      logic            wr_new;
      idx_op_type      idx_op;
      logic            set_ok;
      logic            set_popped;
      logic            finish;
   } spq_cmd_type;

   typedef struct packed {
      logic mode_pop;
      logic count_zero;
      logic count_one;
      logic count_full;
      logic prio_le;
      logic idx_is_one;
      logic idx_next_last;
      logic rsp_free;
   } spq_status_type;

endpackage

// ===== rtl/spq_ctrl.sv =====
// sequencing state machine for insertion and removal
module spq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  spq_pkg::spq_status_type status,
   output spq_pkg::spq_cmd_type    cmd
);
   import spq_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE       = 7'b0000001,
      S_DISPATCH   = 7'b0000010,
      S_PUSH_SCAN  = 7'b0000100,
      S_PUSH_PLACE = 7'b0001000,
      S_POP_HEAD   = 7'b0010000,
      S_POP_SHIFT  = 7'b0100000,
      S_FINISH     = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rd_sel     = RA_ZERO;
      cmd.wa_sel     = WA_IDX;
      cmd.idx_op     = IDX_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.mode_pop) begin
               if (status.count_zero) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RA_ZERO;
                  state_in   = S_POP_HEAD;
               end
            end else if (status.count_full) begin
               state_in = S_FINISH;
            end else if (status.count_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_new = 1'b1;
               cmd.wa_sel = WA_IDX;
               cmd.set_ok = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_IDX_M1;
               state_in   = S_PUSH_SCAN;
            end
         end
         S_PUSH_SCAN: begin
            if (status.prio_le) begin
               cmd.wr_en  = 1'b1;
               cmd.wa_sel = WA_IDX;
               cmd.idx_op = IDX_DEC;
               if (status.idx_is_one) begin
                  state_in = S_PUSH_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RA_IDX_M2;
               end
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_new = 1'b1;
               cmd.wa_sel = WA_IDX;
               cmd.set_ok = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_PUSH_PLACE: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_new = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.set_ok = 1'b1;
            state_in   = S_FINISH;
         end
         S_POP_HEAD: begin
            cmd.set_popped = 1'b1;
            cmd.set_ok     = 1'b1;
            if (status.count_one) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_ONE;
               cmd.idx_op = IDX_ONE;
               state_in   = S_POP_SHIFT;
            end
         end
         S_POP_SHIFT: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX_M1;
            if (status.idx_next_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_IDX_P1;
               cmd.idx_op = IDX_INC;
            end
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/spq_datapath.sv =====
// sorted entry memory, request and index registers, result register
module spq_datapath #(
   parameter int unsigned CAPACITY      = spq_pkg::DEFAULT_CAPACITY,
   parameter int unsigned VALUE_BITS    = spq_pkg::DEFAULT_VALUE_BITS,
   parameter int unsigned PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS,
   localparam int unsigned CNT_W        = $clog2(CAPACITY + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_mode,
   input  logic signed [VALUE_BITS-1:0]    req_element,
   input  logic signed [PRIORITY_BITS-1:0] req_priority_req,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic signed [VALUE_BITS-1:0]    rsp_popped_element,
   output logic [CNT_W-1:0]               rsp_occupancy,
   input  spq_pkg::spq_cmd_type           cmd,
   output spq_pkg::spq_status_type        status
);
   import spq_pkg::*;

   localparam int unsigned ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned ENTRY_W = VALUE_BITS + PRIORITY_BITS;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

   logic [ENTRY_W-1:0] mem [CAPACITY];

   logic                     mode_ff;
   logic [VALUE_BITS-1:0]    value_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic [ENTRY_W-1:0]       rdata_ff;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     ok_ff, ok_in;
   logic [VALUE_BITS-1:0]    popped_ff, popped_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_accepted_ff;
   logic [VALUE_BITS-1:0]    rsp_popped_ff;
   logic [CNT_W-1:0]         rsp_occ_ff;

   logic [CNT_W-1:0]   raddr_full;
   logic [CNT_W-1:0]   waddr_full;
   logic [ENTRY_W-1:0] wdata;
   logic [CNT_W-1:0]   count_next;
   logic               rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd.rd_sel)
         RA_IDX_M1: raddr_full = idx_ff - ONE_CNT;
         RA_IDX_M2: raddr_full = idx_ff - TWO_CNT;
         RA_ZERO:   raddr_full = '0;
         RA_ONE:    raddr_full = ONE_CNT;
         RA_IDX_P1: raddr_full = idx_ff + ONE_CNT;
         default:   raddr_full = '0;
      endcase
   end

   assign waddr_full = (cmd.wa_sel == WA_IDX_M1) ? (idx_ff - ONE_CNT) : idx_ff;
   assign wdata      = cmd.wr_new ? {prio_ff, value_ff} : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[waddr_full[ADDR_W-1:0]] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[raddr_full[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         value_ff <= req_element;
         prio_ff  <= req_priority_req;
      end
   end

   always_comb begin
      unique case (cmd.idx_op)
         IDX_HOLD: idx_in = idx_ff;
         IDX_DEC:  idx_in = idx_ff - ONE_CNT;
         IDX_INC:  idx_in = idx_ff + ONE_CNT;
         IDX_ONE:  idx_in = ONE_CNT;
         default:  idx_in = idx_ff;
      endcase
      if (cmd.capture) begin
         idx_in = count_ff;
      end
   end

   always_comb begin
      ok_in     = ok_ff;
      popped_in = popped_ff;
      if (cmd.capture) begin
         ok_in     = 1'b0;
         popped_in = '0;
      end
      if (cmd.set_ok) begin
         ok_in = 1'b1;
      end
      if (cmd.set_popped) begin
         popped_in = rdata_ff[VALUE_BITS-1:0];
      end
   end

   always_comb begin
      count_next = count_ff;
      if (ok_ff) begin
         count_next = (mode_ff == MODE_POP) ? (count_ff - ONE_CNT) : (count_ff + ONE_CNT);
      end
      count_in     = cmd.finish ? count_next : count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      popped_ff <= popped_in;
      if (cmd.finish) begin
         rsp_accepted_ff <= ok_ff;
         rsp_popped_ff   <= popped_ff;
         rsp_occ_ff      <= count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      status.mode_pop      = (mode_ff == MODE_POP);
      status.count_zero    = (count_ff == '0);
      status.count_one     = (count_ff == ONE_CNT);
      status.count_full    = (count_ff == CAP_CNT);
      status.prio_le       = ($signed(rdata_ff[ENTRY_W-1:VALUE_BITS]) <= $signed(prio_ff));
      status.idx_is_one    = (idx_ff == ONE_CNT);
      status.idx_next_last = ((idx_ff + ONE_CNT) == count_ff);
      status.rsp_free      = rsp_free;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_popped_element = rsp_popped_ff;
   assign rsp_occupancy      = rsp_occ_ff;

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// top level of the sorted priority queue
// Bounded priority queue kept as a list sorted by descending priority in a
// single-port-per-direction memory. A push walks from the tail towards the
// head, moving each entry whose priority is lower than or equal to the new
// one up by one slot per cycle, so the newest of equal priorities leaves
// first; a pop reads the head and moves every remaining entry down one slot
// per cycle. One request is worked on at a time. A refused request (push into
// a full queue, pop from an empty one) and a push into an empty queue finish
// without a memory walk; any other push walks over the entries that it
// moves, and a pop over every entry in the queue, one entry per cycle. A
// finished request waits until the previous result has left the output
// register. The result sits in that output register, so the next request
// is taken while a result still waits.
module sorted_priority_queue_unit #(
   parameter int unsigned CAPACITY      = spq_pkg::DEFAULT_CAPACITY,
   parameter int unsigned VALUE_BITS    = spq_pkg::DEFAULT_VALUE_BITS,
   parameter int unsigned PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS,
   localparam int unsigned CNT_W        = $clog2(CAPACITY + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic signed [VALUE_BITS-1:0]    req_element,
   input  logic signed [PRIORITY_BITS-1:0] req_priority_req,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic signed [VALUE_BITS-1:0]    rsp_popped_element,
   output logic [CNT_W-1:0]               rsp_occupancy
);
   import spq_pkg::*;

   spq_cmd_type    cmd;
   spq_status_type status;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spq_datapath #(
      .CAPACITY      (CAPACITY),
      .VALUE_BITS    (VALUE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_mode           (req_mode),
      .req_element        (req_element),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_popped_element (rsp_popped_element),
      .rsp_occupancy      (rsp_occupancy),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// ===== rtl/spq_checker.sv =====
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker #(
   parameter int unsigned CAPACITY      = spq_pkg::DEFAULT_CAPACITY,
   parameter int unsigned VALUE_BITS    = spq_pkg::DEFAULT_VALUE_BITS,
   parameter int unsigned PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS,
   localparam int unsigned CNT_W        = $clog2(CAPACITY + 1)
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_mode,
   input logic [VALUE_BITS-1:0]    req_element,
   input logic [PRIORITY_BITS-1:0] req_priority_req,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_accepted,
   input logic [VALUE_BITS-1:0]    rsp_popped_element,
   input logic [CNT_W-1:0]         rsp_occupancy
);
   import spq_pkg::*;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !$isunknown({req_mode, req_element, req_priority_req}))
      else $error("request fields unknown while valid");

   // refused results carry no element; push results carry none either, but only refused ones are checked here
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_popped_element == '0))
      else $error("refused request returned a non-zero element");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CAP_CNT))
      else $error("occupancy above capacity");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another was in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_occupancy)
         && $stable(rsp_accepted)))
      else $error("stalled result changed");

endmodule

bind sorted_priority_queue_unit spq_checker #(
   .CAPACITY      (CAPACITY),
   .VALUE_BITS    (VALUE_BITS),
   .PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (.*);
